@@ src/sbrt_pkg.sv @@
`default_nettype none

package sbrt_pkg;

    localparam int DATA_W = 32;
    localparam int LIM_W  = 31;

    localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7fff_ffff;
    localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;

    localparam logic [LIM_W-1:0] BOX_LIMIT_RST = 31'd65536;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DIV,
        ST_MERGE,
        ST_EMIT
    } t_state;

    // one division request: magnitudes plus the sign of the quotient
    typedef struct packed {
        logic              start;
        logic              neg;
        logic [DATA_W-1:0] num;
        logic [DATA_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic                     done;
        logic signed [DATA_W-1:0] quot;
    } t_div_rsp;

endpackage

`default_nettype wire

@@ src/sbrt_div.sv @@
`default_nettype none

module sbrt_div #(
    parameter int FRAC_BITS = 16
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  sbrt_pkg::t_div_req i_req,
    output sbrt_pkg::t_div_rsp o_rsp
);
    import sbrt_pkg::*;

    localparam int QW = DATA_W + FRAC_BITS;
    localparam int CW = $clog2(QW + 1);

    logic [QW-1:0]     r_dvd, n_dvd;
    logic [DATA_W-1:0] r_rem, n_rem;
    logic [DATA_W-1:0] r_den;
    logic [CW-1:0]     r_cnt, n_cnt;
    logic              r_neg;
    logic              r_busy, n_busy;
    logic              r_done, n_done;

    logic [DATA_W-1:0] trial;
    logic              ge;
    logic              q_high;
    logic [DATA_W-1:0] q_low;

    // shared subtractor: one quotient bit per cycle, msb first
    assign trial = {r_rem[DATA_W-2:0], r_dvd[QW-1]};
    assign ge    = (trial >= r_den);

    always_comb begin
        n_dvd  = r_dvd;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_req.start) begin
            n_dvd  = {i_req.num, {FRAC_BITS{1'b0}}};
            n_rem  = '0;
            n_cnt  = CW'(QW);
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_rem = ge ? (trial - r_den) : trial;
            n_dvd = {r_dvd[QW-2:0], ge};
            n_cnt = r_cnt - CW'(1);
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_dvd <= n_dvd;
        r_rem <= n_rem;
        if (i_req.start) begin
            r_den <= i_req.den;
            r_neg <= i_req.neg;
        end
    end

    // saturate the unsigned quotient into the signed range
    assign q_high = |r_dvd[QW-1:DATA_W];
    assign q_low  = r_dvd[DATA_W-1:0];

    always_comb begin
        o_rsp.done = r_done;
        if (r_neg) begin
            if (q_high || (q_low > DATA_W'(Q_MIN))) begin
                o_rsp.quot = Q_MIN;
            end else begin
                o_rsp.quot = DATA_W'(-q_low);
            end
        end else begin
            if (q_high || q_low[DATA_W-1]) begin
                o_rsp.quot = Q_MAX;
            end else begin
                o_rsp.quot = q_low;
            end
        end
    end

endmodule

`default_nettype wire

@@ src/step_bound_ratio_test.sv @@
// flow: a nonzero-direction element passes from its transfer through load, 32 + FRAC_BITS
// divider steps, order and merge
// zero-direction elements skip the dividers; a last element adds an emit for the result
// throughput: one element at a time, set by the bit-serial dividers run side by side
// reset: synchronous active low, box limit returns to 1.0 and the running interval rearms
`default_nettype none

module step_bound_ratio_test #(
    parameter int FRAC_BITS = 16
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // config write
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [30:0] i_cfg_data,       // box_limit
    // element stream in
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  wire  [63:0] i_s_axis_tdata,   // base_value [31:0], direction_value [63:32]
    input  wire         i_s_axis_tlast,   // last_element
    // result stream out
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // step_upper
    output logic        o_m_axis_tuser    // infeasible
);
    import sbrt_pkg::*;

    localparam logic [DATA_W-1:0] NEG_ONE = ~((DATA_W'(1) << FRAC_BITS) - DATA_W'(1));

    t_state r_state, n_state;

    logic [LIM_W-1:0]         r_box_limit;
    logic signed [DATA_W-1:0] r_base, r_dir;
    logic                     r_last;
    logic signed [DATA_W-1:0] r_hi, n_hi, r_lo, n_lo;
    logic signed [DATA_W-1:0] r_run_upper, n_run_upper, r_run_lower, n_run_lower;
    logic                     r_first, n_first, r_forced, n_forced;
    logic                     r_out_valid, n_out_valid;
    logic [DATA_W-1:0]        r_out_data, n_out_data;
    logic                     r_out_infeas, n_out_infeas;
    logic                     in_xfer;

    t_div_req req_a, req_c;
    t_div_rsp rsp_a, rsp_c;

    logic signed [DATA_W+1:0] lim_x, base_x, num_a, num_c;
    logic [DATA_W+1:0]        mag_a, mag_c;
    logic [DATA_W-1:0]        mag_d, mag_b;
    logic                     dir_zero;

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign in_xfer         = i_s_axis_tvalid & o_s_axis_tready;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_infeas;

    // numerators (L - b) and (-L - b) are exact at 34 bits, magnitudes fit 32
    assign lim_x    = {3'b000, r_box_limit};
    assign base_x   = {{2{r_base[DATA_W-1]}}, r_base};
    assign num_a    = lim_x - base_x;
    assign num_c    = -lim_x - base_x;
    assign mag_a    = num_a[DATA_W+1] ? (~num_a + 1'b1) : num_a;
    assign mag_c    = num_c[DATA_W+1] ? (~num_c + 1'b1) : num_c;
    assign mag_d    = r_dir[DATA_W-1] ? (~r_dir + 1'b1) : r_dir;
    assign mag_b    = r_base[DATA_W-1] ? (~r_base + 1'b1) : r_base;
    assign dir_zero = (r_dir == '0);

    always_comb begin
        req_a.start = (r_state == ST_LOAD) && !dir_zero;
        req_a.neg   = num_a[DATA_W+1] ^ r_dir[DATA_W-1];
        req_a.num   = mag_a[DATA_W-1:0];
        req_a.den   = mag_d;
        req_c.start = (r_state == ST_LOAD) && !dir_zero;
        req_c.neg   = num_c[DATA_W+1] ^ r_dir[DATA_W-1];
        req_c.num   = mag_c[DATA_W-1:0];
        req_c.den   = mag_d;
    end

    sbrt_div #(.FRAC_BITS(FRAC_BITS)) u_div_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_a),
        .o_rsp   (rsp_a)
    );

    sbrt_div #(.FRAC_BITS(FRAC_BITS)) u_div_c (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_c),
        .o_rsp   (rsp_c)
    );

    always_comb begin
        n_state      = r_state;
        n_hi         = r_hi;
        n_lo         = r_lo;
        n_run_upper  = r_run_upper;
        n_run_lower  = r_run_lower;
        n_first      = r_first;
        n_forced     = r_forced;
        n_out_valid  = r_out_valid & ~i_m_axis_tready;
        n_out_data   = r_out_data;
        n_out_infeas = r_out_infeas;
        unique case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD: begin
                if (dir_zero) begin
                    // no constraint, unless the value is already outside the box
                    n_hi = Q_MAX;
                    n_lo = Q_MIN;
                    if (mag_b > DATA_W'(r_box_limit)) begin
                        n_forced = 1'b1;
                    end
                    n_state = ST_MERGE;
                end else begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (rsp_a.done) begin
                    if (rsp_c.quot > rsp_a.quot) begin
                        n_hi = rsp_c.quot;
                        n_lo = rsp_a.quot;
                    end else begin
                        n_hi = rsp_a.quot;
                        n_lo = rsp_c.quot;
                    end
                    n_state = ST_MERGE;
                end
            end
            ST_MERGE: begin
                if (r_first) begin
                    n_run_upper = r_hi;
                    n_run_lower = r_lo;
                    n_first     = 1'b0;
                end else begin
                    if (r_hi < r_run_upper) begin
                        n_run_upper = r_hi;
                    end
                    if (r_lo > r_run_lower) begin
                        n_run_lower = r_lo;
                    end
                end
                n_state = r_last ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT: begin
                // wait for the output register to free up
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_valid = 1'b1;
                    if (r_forced || (r_run_lower > r_run_upper)) begin
                        n_out_data   = NEG_ONE;
                        n_out_infeas = 1'b1;
                    end else begin
                        n_out_data   = r_run_upper;
                        n_out_infeas = 1'b0;
                    end
                    n_first  = 1'b1;
                    n_forced = 1'b0;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box_limit <= BOX_LIMIT_RST;
            r_run_upper <= '0;
            r_run_lower <= '0;
            r_first     <= 1'b1;
            r_forced    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_box_limit <= i_cfg_data;
            end
            r_run_upper <= n_run_upper;
            r_run_lower <= n_run_lower;
            r_first     <= n_first;
            r_forced    <= n_forced;
            r_out_valid <= n_out_valid;
        end
        if (in_xfer) begin
            r_base <= i_s_axis_tdata[31:0];
            r_dir  <= i_s_axis_tdata[63:32];
            r_last <= i_s_axis_tlast;
        end
        r_hi         <= n_hi;
        r_lo         <= n_lo;
        r_out_data   <= n_out_data;
        r_out_infeas <= n_out_infeas;
    end

endmodule

`default_nettype wire

@@ tb/sv/step_bound_ratio_test_test.sv @@
module step_bound_ratio_test_test;
    timeunit 1ns;
    timeprecision 1ps;

    import sbrt_pkg::*;

    localparam int FRAC_BITS    = 16;
    localparam int QUIET_CYCLES = 40 + FRAC_BITS + 8;
    localparam int TAIL_CYCLES  = 64;
    localparam int RANDOM_ITEMS = 450;
    localparam logic signed [DATA_W-1:0] MINUS_ONE = -(32'sd1 <<< FRAC_BITS);

    typedef enum logic [1:0] {
        ENT_ELEM,
        ENT_LIMIT,
        ENT_DRAIN
    } t_entry_kind;

    typedef struct {
        t_entry_kind       kind;
        logic [DATA_W-1:0] base;
        logic [DATA_W-1:0] dir;
        logic              last;
        logic [LIM_W-1:0]  limit;
    } t_entry;

    typedef struct {
        logic signed [DATA_W-1:0] step_upper;
        logic                     infeasible;
    } t_bound;

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_cfg_valid     = 1'b0;
    logic [30:0] i_cfg_data      = '0;
    logic        i_s_axis_tvalid = 1'b0;
    logic [63:0] i_s_axis_tdata  = '0;
    logic        i_s_axis_tlast  = 1'b0;
    logic        i_m_axis_tready = 1'b0;
    logic        o_cfg_ready;
    logic        o_s_axis_tready;
    logic        o_m_axis_tvalid;
    logic [31:0] o_m_axis_tdata;
    logic        o_m_axis_tuser;

    step_bound_ratio_test #(
        .FRAC_BITS(FRAC_BITS)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .i_s_axis_tlast (i_s_axis_tlast),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata),
        .o_m_axis_tuser (o_m_axis_tuser)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    t_entry pend_q[$];
    t_bound bound_q[$];

    // interval tracker state
    logic [LIM_W-1:0]         lim_model    = BOX_LIMIT_RST;
    logic signed [DATA_W-1:0] upper_run    = '0;
    logic signed [DATA_W-1:0] lower_run    = '0;
    logic                     first_due    = 1'b1;
    logic                     empty_forced = 1'b0;

    int          results_due     = 0;
    int          results_seen    = 0;
    int          infeasible_seen = 0;
    int          elements_sent   = 0;
    int          zero_dir_sent   = 0;
    int          limit_writes    = 0;
    int          mismatches      = 0;
    int          calm_after      = 0;
    int          gap_cnt         = 0;
    int          stall_cnt       = 0;
    int          quiet_cnt       = QUIET_CYCLES;
    logic [15:0] cyc_cnt         = '0;
    logic        stim_done       = 1'b0;
    logic        idle_ok;

    // idling only in alternating windows, never near the end
    assign idle_ok = cyc_cnt[8] && (elements_sent < calm_after);

    // (num << FRAC_BITS) / den, truncated toward zero, saturated to 32 bits
    function automatic logic signed [DATA_W-1:0] step_quotient(input longint num,
                                                              input longint den);
        logic        neg;
        logic [63:0] n;
        logic [63:0] dv;
        logic [63:0] q;
        logic [63:0] neg_q;
        neg = (num < 0) != (den < 0);
        n   = (num < 0) ? -num : num;
        dv  = (den < 0) ? -den : den;
        q   = (n << FRAC_BITS) / dv;
        if (neg) begin
            if (q > 64'd2147483648)
                return Q_MIN;
            neg_q = -q;
            return neg_q[31:0];
        end
        if (q > 64'd2147483647)
            return Q_MAX;
        return q[31:0];
    endfunction

    task automatic predict_element(input logic signed [DATA_W-1:0] base,
                                   input logic signed [DATA_W-1:0] dir,
                                   input logic                     last);
        longint                   b;
        longint                   d;
        longint                   lim;
        logic signed [DATA_W-1:0] lo;
        logic signed [DATA_W-1:0] hi;
        logic signed [DATA_W-1:0] qa;
        logic signed [DATA_W-1:0] qc;
        t_bound                   res;
        b   = base;
        d   = dir;
        lim = longint'(lim_model);
        if (d == 0) begin
            // no constraint unless the element already sits outside the box
            lo = Q_MIN;
            hi = Q_MAX;
            if ((b < 0 ? -b : b) > lim)
                empty_forced = 1'b1;
        end else begin
            qa = step_quotient(lim - b, d);
            qc = step_quotient(-lim - b, d);
            if (qc > qa) begin
                hi = qc;
                lo = qa;
            end else begin
                hi = qa;
                lo = qc;
            end
        end
        if (first_due) begin
            upper_run = hi;
            lower_run = lo;
            first_due = 1'b0;
        end else begin
            if (hi < upper_run)
                upper_run = hi;
            if (lo > lower_run)
                lower_run = lo;
        end
        if (last) begin
            if (empty_forced || lower_run > upper_run) begin
                res.step_upper = MINUS_ONE;
                res.infeasible = 1'b1;
            end else begin
                res.step_upper = upper_run;
                res.infeasible = 1'b0;
            end
            bound_q.push_back(res);
            results_due  = results_due + 1;
            first_due    = 1'b1;
            empty_forced = 1'b0;
        end
    endtask

    function automatic void add_elem(input logic [DATA_W-1:0] b, input logic [DATA_W-1:0] d,
                                     input logic last);
        t_entry e;
        e.kind  = ENT_ELEM;
        e.base  = b;
        e.dir   = d;
        e.last  = last;
        e.limit = '0;
        pend_q.push_back(e);
    endfunction

    function automatic void add_limit(input logic [LIM_W-1:0] v);
        t_entry e;
        e.kind  = ENT_LIMIT;
        e.base  = '0;
        e.dir   = '0;
        e.last  = 1'b0;
        e.limit = v;
        pend_q.push_back(e);
    endfunction

    function automatic void add_drain();
        t_entry e;
        e.kind  = ENT_DRAIN;
        e.base  = '0;
        e.dir   = '0;
        e.last  = 1'b0;
        e.limit = '0;
        pend_q.push_back(e);
    endfunction

    // element and limit driver
    always @(posedge i_clk) begin : drive
        t_entry      head;
        logic        elem_fire;
        logic        cfg_fire;
        logic        nv_elem;
        logic        nv_cfg;
        logic        nv_last;
        logic [63:0] nv_data;
        logic [30:0] nv_cfg_data;
        int          nv_gap;
        int          nv_quiet;
        cyc_cnt <= cyc_cnt + 1'b1;
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
            i_s_axis_tdata  <= '0;
            i_s_axis_tlast  <= 1'b0;
            i_cfg_valid     <= 1'b0;
            i_cfg_data      <= '0;
            gap_cnt         <= 0;
            quiet_cnt       <= QUIET_CYCLES;
            stim_done       <= 1'b0;
            lim_model       = BOX_LIMIT_RST;
            upper_run       = '0;
            lower_run       = '0;
            first_due       = 1'b1;
            empty_forced    = 1'b0;
        end else begin
            elem_fire   = i_s_axis_tvalid && o_s_axis_tready;
            cfg_fire    = i_cfg_valid && o_cfg_ready;
            nv_elem     = i_s_axis_tvalid && !elem_fire;
            nv_cfg      = i_cfg_valid && !cfg_fire;
            nv_data     = i_s_axis_tdata;
            nv_last     = i_s_axis_tlast;
            nv_cfg_data = i_cfg_data;
            nv_gap      = gap_cnt;
            nv_quiet    = (quiet_cnt < QUIET_CYCLES) ? quiet_cnt + 1 : quiet_cnt;
            if (elem_fire) begin
                predict_element(i_s_axis_tdata[31:0], i_s_axis_tdata[63:32], i_s_axis_tlast);
                elements_sent <= elements_sent + 1;
                if (i_s_axis_tdata[63:32] == '0)
                    zero_dir_sent <= zero_dir_sent + 1;
                nv_quiet = 0;
                if (idle_ok && $urandom_range(0, 3) == 0)
                    nv_gap = $urandom_range(1, 9);
            end
            if (cfg_fire) begin
                lim_model = i_cfg_data;
                limit_writes <= limit_writes + 1;
            end
            if (!nv_elem && !nv_cfg) begin
                if (nv_gap != 0) begin
                    nv_gap = nv_gap - 1;
                end else if (pend_q.size() != 0) begin
                    head = pend_q[0];
                    case (head.kind)
                        ENT_ELEM: begin
                            nv_elem = 1'b1;
                            nv_data = {head.dir, head.base};
                            nv_last = head.last;
                            void'(pend_q.pop_front());
                        end
                        ENT_LIMIT: begin
                            // block must be idle: results in and last element worked off
                            if (results_seen == results_due && nv_quiet >= QUIET_CYCLES) begin
                                nv_cfg      = 1'b1;
                                nv_cfg_data = head.limit;
                                void'(pend_q.pop_front());
                            end
                        end
                        ENT_DRAIN: begin
                            if (results_seen == results_due)
                                void'(pend_q.pop_front());
                        end
                        default: void'(pend_q.pop_front());
                    endcase
                end
            end
            i_s_axis_tvalid <= nv_elem;
            i_s_axis_tdata  <= nv_data;
            i_s_axis_tlast  <= nv_last;
            i_cfg_valid     <= nv_cfg;
            i_cfg_data      <= nv_cfg_data;
            gap_cnt         <= nv_gap;
            quiet_cnt       <= nv_quiet;
            stim_done       <= !nv_elem && !nv_cfg && (pend_q.size() == 0);
        end
    end

    // result sink with random stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
            stall_cnt       <= 0;
        end else if (stall_cnt != 0) begin
            i_m_axis_tready <= 1'b0;
            stall_cnt       <= stall_cnt - 1;
        end else if (idle_ok && $urandom_range(0, 2) == 0) begin
            i_m_axis_tready <= 1'b0;
            stall_cnt       <= $urandom_range(0, 8);
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    // result checker
    always @(posedge i_clk) begin : check
        t_bound want;
        int     bad;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            bad = 0;
            if (bound_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, got step_upper %h infeasible %b",
                         $time, o_m_axis_tdata, o_m_axis_tuser);
                bad = 1;
            end else begin
                want = bound_q.pop_front();
                if (o_m_axis_tdata !== want.step_upper) begin
                    $display("%0t: step_upper mismatch, expected %h, got %h",
                             $time, want.step_upper, o_m_axis_tdata);
                    bad = bad + 1;
                end
                if (o_m_axis_tuser !== want.infeasible) begin
                    $display("%0t: infeasible mismatch, expected %b, got %b",
                             $time, want.infeasible, o_m_axis_tuser);
                    bad = bad + 1;
                end
            end
            mismatches   <= mismatches + bad;
            results_seen <= results_seen + 1;
            if (o_m_axis_tuser === 1'b1)
                infeasible_seen <= infeasible_seen + 1;
        end
    end

    initial begin
        #5_000_000;
        $display("timeout with %0d results outstanding", bound_q.size());
        $display("step_bound_ratio_test regression: fail");
        $finish;
    end

    initial begin : stimulus
        int unsigned gen_lim;
        int unsigned span;
        int          gen_elems;
        int          phase_end;
        int          vec_len;
        int          k;
        logic        well;
        logic [31:0] b;
        logic [31:0] d;

        // directed, limit at its reset value of 1.0
        add_elem(32'h0000_0000, 32'h0001_0000, 1'b1);
        add_elem(32'h7fff_ffff, 32'h8000_0000, 1'b1);
        add_elem(32'h8000_0000, 32'h7fff_ffff, 1'b1);
        add_elem(32'h0000_8000, 32'h0000_0000, 1'b1);   // zero direction inside the box
        add_elem(32'h0002_0000, 32'h0000_0000, 1'b1);   // zero direction outside the box
        add_elem(32'hfffe_0000, 32'h0000_0000, 1'b0);   // outside mid-vector
        add_elem(32'h0000_0000, 32'h0001_0000, 1'b1);
        add_elem(32'h0000_0000, 32'h0000_0000, 1'b0);   // full range as first element
        add_elem(32'h0000_8000, 32'hffff_0000, 1'b1);
        add_elem(32'h0000_0000, 32'h0001_0000, 1'b0);   // disjoint intervals
        add_elem(32'hfffd_0000, 32'h0001_0000, 1'b1);
        add_elem(32'h0000_0000, 32'h0000_0001, 1'b1);   // quotients saturate
        add_elem(32'h0000_0000, 32'hffff_ffff, 1'b1);
        add_elem(32'h0000_4000, 32'h0002_0000, 1'b0);
        add_elem(32'hffff_c000, 32'hfffe_8000, 1'b0);
        add_elem(32'h0000_1000, 32'h0003_0000, 1'b1);
        add_drain();
        add_limit(31'd0);
        add_elem(32'h0000_0000, 32'h0001_0000, 1'b1);   // equal ends
        add_elem(32'h0000_0010, 32'h0000_0000, 1'b1);
        add_elem(32'h0000_0000, 32'h0000_0000, 1'b1);
        add_limit(31'h7fff_ffff);
        add_elem(32'h8000_0000, 32'h0001_0000, 1'b1);
        add_elem(32'h7fff_ffff, 32'h8000_0000, 1'b0);
        add_elem(32'h8000_0000, 32'h0000_0000, 1'b1);
        gen_elems = 22;
        gen_lim   = 32'h7fff_ffff;

        while (gen_elems < 22 + RANDOM_ITEMS) begin
            case ($urandom_range(0, 5))
                0:       gen_lim = 0;
                1:       gen_lim = 32'h7fff_ffff;
                2:       gen_lim = 32'h0001_0000;
                3, 4:    gen_lim = $urandom_range(1, 32'h0020_0000);
                default: gen_lim = $urandom & 32'h7fff_ffff;
            endcase
            add_limit(gen_lim[30:0]);
            phase_end = gen_elems + $urandom_range(30, 70);
            while (gen_elems < phase_end) begin
                vec_len = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 12)
                                                      : $urandom_range(1, 4);
                // mostly vectors whose elements sit inside the box, so step 0 stays feasible
                well = $urandom_range(0, 9) < 7;
                for (k = 0; k < vec_len; k++) begin
                    if (well) begin
                        span = 2 * gen_lim;
                        b = (gen_lim == 0) ? 32'h0
                          : 32'(longint'($urandom_range(0, span)) - longint'(gen_lim));
                    end else begin
                        case ($urandom_range(0, 3))
                            0, 1:    b = $urandom;
                            2:       b = gen_lim + $urandom_range(1, 32'h0001_0000);
                            default: b = -gen_lim - $urandom_range(1, 32'h0001_0000);
                        endcase
                    end
                    case ($urandom_range(0, 9))
                        0: d = 32'h0;
                        1: d = $urandom;
                        2: begin
                            case ($urandom_range(0, 3))
                                0:       d = 32'h7fff_ffff;
                                1:       d = 32'h8000_0000;
                                2:       d = 32'h0000_0001;
                                default: d = 32'hffff_ffff;
                            endcase
                        end
                        3: d = $urandom_range(1, 255);
                        default: d = $urandom_range(32'h100, 32'h7_ffff);
                    endcase
                    if ($urandom_range(0, 1) == 1)
                        d = -d;
                    add_elem(b, d, k == vec_len - 1);
                    gen_elems++;
                end
                if ($urandom_range(0, 15) == 0)
                    add_drain();
            end
        end
        calm_after = gen_elems - 60;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (!stim_done) @(posedge i_clk);
        while (results_seen != results_due) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (bound_q.size() != 0)
            $display("%0t: %0d expected results never arrived", $time, bound_q.size());
        $display("sent %0d elements (%0d with zero direction), checked %0d vector bounds",
                 elements_sent, zero_dir_sent, results_seen);
        $display("%0d bounds were infeasible, box limit rewritten %0d times incl. 0 and max",
                 infeasible_seen, limit_writes);
        if (mismatches == 0 && bound_q.size() == 0) begin
            $display("step_bound_ratio_test regression: pass");
        end else begin
            $display("step_bound_ratio_test regression: fail");
        end
        $finish;
    end

endmodule
